// ===== rtl/owsh_pkg.sv =====
// Shared constants, types and the table generator step for the one-way string hash.
package owsh_pkg;

	localparam int NUM_HASH_TYPES = 5;
	localparam int SLICE_WORDS    = 256;
	localparam int TABLE_WORDS    = NUM_HASH_TYPES * SLICE_WORDS;
	localparam int TBL_AW         = $clog2(TABLE_WORDS);
	localparam int SLICE_W        = (NUM_HASH_TYPES > 1) ? $clog2(NUM_HASH_TYPES) : 1;

	localparam logic [21:0] LCG_SEED = 22'h100001;
	localparam logic [21:0] LCG_MOD  = 22'h2AAAAB;

	localparam logic [31:0] SEED_A_INIT = 32'h7FED7FED;
	localparam logic [31:0] SEED_B_INIT = 32'hEEEEEEEE;

	typedef struct packed {
		logic              valid;
		logic              no_char;
		logic              last;
		logic              oob;
		logic [7:0]        char_byte;
	} s1_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [31:0]       data;
	} tbl_wr_t;

	// (s*125+3) mod 0x2AAAAB. Since 3*0x2AAAAB = 2^23+1, floor(3x/2^23) is the
	// quotient or one above it; one add-back fixes the remainder.
	function automatic logic [21:0] lcg_next(input logic [21:0] s);
		logic [28:0] x;
		logic [30:0] x3;
		logic [7:0]  q;
		logic [29:0] prod;
		logic [29:0] r;
		x    = 29'(s) * 29'd125 + 29'd3;
		x3   = 31'(x) * 31'd3;
		q    = x3[30:23];
		prod = 30'(q) * 30'(LCG_MOD);
		r    = 30'(x) - prod;
		if (r[29]) begin
			r = r + 30'(LCG_MOD);
		end
		return r[21:0];
	endfunction

endpackage

// ===== rtl/owsh_if.sv =====
// Valid/ready stream interfaces for key bytes in and hash results out.
interface owsh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       no_char;
	logic       last;

	modport source (output valid, output char_byte, output no_char, output last, input ready);
	modport sink   (input valid, input char_byte, input no_char, input last, output ready);
endinterface

interface owsh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== rtl/owsh_table_gen.sv =====
// Builds the crypt table after reset from the linear congruential sequence.
module owsh_table_gen (
	input  logic              clk,
	input  logic              arst_n,
	output owsh_pkg::tbl_wr_t wr,
	output logic              done
);

	logic [21:0]                  seed_q;
	logic                         phase_q;
	logic [15:0]                  hi_q;
	logic [7:0]                   col_q;
	logic [owsh_pkg::SLICE_W-1:0] slice_q;
	logic                         done_q;
	logic [21:0]                  seed_n;
	logic                         slice_wrap;

	assign seed_n     = owsh_pkg::lcg_next(seed_q);
	assign slice_wrap = (slice_q == owsh_pkg::SLICE_W'(owsh_pkg::NUM_HASH_TYPES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= owsh_pkg::LCG_SEED;
			phase_q <= 1'b0;
			hi_q    <= '0;
			col_q   <= '0;
			slice_q <= '0;
			done_q  <= 1'b0;
		end else if (!done_q) begin
			seed_q  <= seed_n;
			phase_q <= ~phase_q;
			if (!phase_q) begin
				hi_q <= seed_n[15:0];
			end else begin
				// word written this cycle; step slice first, then column
				if (slice_wrap) begin
					slice_q <= '0;
					col_q   <= col_q + 8'd1;
					if (col_q == 8'hFF) begin
						done_q <= 1'b1;
					end
				end else begin
					slice_q <= slice_q + owsh_pkg::SLICE_W'(1);
				end
			end
		end
	end

	always_comb begin
		wr.en   = !done_q && phase_q;
		wr.addr = owsh_pkg::TBL_AW'(int'(slice_q) * owsh_pkg::SLICE_WORDS + int'(col_q));
		wr.data = {hi_q, seed_n[15:0]};
	end

	assign done = done_q;

endmodule

// ===== rtl/owsh_crypt_ram.sv =====
// Crypt table storage: one write port for the build, one registered read port.
module owsh_crypt_ram (
	input  logic                        clk,
	input  owsh_pkg::tbl_wr_t           wr,
	input  logic                        rd_en,
	input  logic [owsh_pkg::TBL_AW-1:0] rd_addr,
	output logic [31:0]                 rd_data
);

	logic [31:0] mem [owsh_pkg::TABLE_WORDS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/owsh_seed_update.sv =====
// Running seed pair: folds one table word and byte into the seeds per character item.
module owsh_seed_update (
	input  logic          clk,
	input  logic          arst_n,
	input  owsh_pkg::s1_t step,
	input  logic          adv,
	input  logic [31:0]   tbl_word,
	output logic [31:0]   res_val
);

	logic [31:0] seed_a_q;
	logic [31:0] seed_b_q;
	logic [31:0] word;
	logic [31:0] a_n;
	logic [31:0] b_n;

	// slices beyond the table read as zero
	assign word = step.oob ? 32'h0 : tbl_word;
	assign a_n  = word ^ (seed_a_q + seed_b_q);
	assign b_n  = 32'(step.char_byte) + a_n + seed_b_q + (seed_b_q << 5) + 32'd3;

	assign res_val = step.no_char ? seed_a_q : a_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= owsh_pkg::SEED_A_INIT;
			seed_b_q <= owsh_pkg::SEED_B_INIT;
		end else if (adv && step.valid) begin
			if (step.last) begin
				// restart for the next string
				seed_a_q <= owsh_pkg::SEED_A_INIT;
				seed_b_q <= owsh_pkg::SEED_B_INIT;
			end else if (!step.no_char) begin
				seed_a_q <= a_n;
				seed_b_q <= b_n;
			end
		end
	end

endmodule

// ===== rtl/one_way_string_hash_unit.sv =====
// Top level of the one-way string hash unit.
// After reset the unit builds its 1280-word crypt table, and input ready
// stays low until the build is done; configuration writes are taken during
// that time. Afterwards one key byte is accepted per cycle while the pipe is
// not held. Each accepted transaction reads the table at the edge it is taken
// and is registered into stage 1, where the seed update runs; the hash of a
// string is loaded into the output register from stage 1 once that register
// is empty or being taken. The output register lets bytes keep flowing while a
// result waits; only a last byte behind an untaken result holds the pipe.
// hash_type must be changed only while no string is in flight.
module one_way_string_hash_unit (
	input  logic              clk,
	input  logic              arst_n,
	owsh_in_if.sink           in_ch,
	owsh_out_if.source        out_ch,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_wr_data
);

	logic [2:0]                  hash_type_q;
	owsh_pkg::tbl_wr_t           tbl_wr;
	logic                        fill_done;
	owsh_pkg::s1_t               item_s1;
	logic                        adv;
	logic                        in_acc;
	logic                        oob;
	logic [owsh_pkg::TBL_AW-1:0] rd_addr;
	logic [31:0]                 tbl_word;
	logic [31:0]                 res_val;
	logic                        res_load;
	logic                        out_valid_q;
	logic [31:0]                 out_hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_type_q <= '0;
		end else if (cfg_wr_en) begin
			hash_type_q <= cfg_wr_data;
		end
	end

	owsh_table_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.done   (fill_done)
	);

	// hold stage 1 only when it carries a result and the output is still full
	assign adv    = !(item_s1.valid && item_s1.last && out_valid_q && !out_ch.ready);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = fill_done && adv;

	assign oob     = (hash_type_q >= 3'(owsh_pkg::NUM_HASH_TYPES));
	assign rd_addr = oob ? '0 : owsh_pkg::TBL_AW'({hash_type_q, in_ch.char_byte});

	owsh_crypt_ram u_ram (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_en   (adv),
		.rd_addr (rd_addr),
		.rd_data (tbl_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1.valid     <= in_acc;
			item_s1.no_char   <= in_ch.no_char;
			item_s1.last      <= in_ch.last;
			item_s1.oob       <= oob;
			item_s1.char_byte <= in_ch.char_byte;
		end
	end

	owsh_seed_update u_seed (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (item_s1),
		.adv      (adv),
		.tbl_word (tbl_word),
		.res_val  (res_val)
	);

	assign res_load = adv && item_s1.valid && item_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_hash_q <= res_val;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.hash_value = out_hash_q;

`ifndef SYNTHESIS
	a_no_input_before_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> fill_done)
		else $error("input taken before crypt table is built");

	a_fill_stays_done: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |=> fill_done)
		else $error("crypt table build restarted");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> out_valid_q)
		else $error("last transaction produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !res_load)
		else $error("pending result overwritten");
`endif

endmodule

// ===== sim/one_way_string_hash_unit_tb.sv =====
// Self-checking testbench for the one-way string hash unit: random key strings, all hash types.
module one_way_string_hash_unit_tb;

	typedef struct {
		logic [7:0] ch;
		logic       none;
		logic       fin;
	} key_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic       cfg_wr_en;
	logic [2:0] cfg_wr_data;

	owsh_in_if  in_ch();
	owsh_out_if out_ch();

	one_way_string_hash_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Local copy of the hash state
	logic [31:0] crypt_words [0:owsh_pkg::TABLE_WORDS-1];
	logic [31:0] seed_a;
	logic [31:0] seed_b;
	logic [2:0]  sel_type;

	key_item_t   key_q[$];
	logic [31:0] hash_q[$];
	key_item_t   cur_key;

	bit          in_taken;
	bit          out_taken;
	bit          send_idle;
	bit          recv_idle;
	bit          hold_req;
	bit          rx_hold;
	int unsigned send_gap;
	int unsigned recv_gap;

	int n_bad;
	int n_keys;
	int n_strings;
	int n_hashes;
	int n_settings;

	function automatic void build_crypt_words();
		logic [63:0] s;
		logic [15:0] hi;
		s = 64'h100001;
		for (int col = 0; col < owsh_pkg::SLICE_WORDS; col++) begin
			for (int slice = 0; slice < owsh_pkg::NUM_HASH_TYPES; slice++) begin
				s  = (s * 125 + 3) % 64'h2AAAAB;
				hi = s[15:0];
				s  = (s * 125 + 3) % 64'h2AAAAB;
				crypt_words[slice * owsh_pkg::SLICE_WORDS + col] = {hi, s[15:0]};
			end
		end
	endfunction

	// Fold one transaction into the seeds; a last transaction yields a hash
	task automatic absorb_key_byte(input key_item_t it);
		logic [31:0] word;
		logic [31:0] na;
		if (!it.none) begin
			word = 32'd0;
			if (sel_type < owsh_pkg::NUM_HASH_TYPES)
				word = crypt_words[int'(sel_type) * owsh_pkg::SLICE_WORDS + int'(it.ch)];
			na     = word ^ (seed_a + seed_b);
			seed_b = {24'd0, it.ch} + na + seed_b + (seed_b << 5) + 32'd3;
			seed_a = na;
		end
		if (it.fin) begin
			hash_q.push_back(seed_a);
			seed_a = owsh_pkg::SEED_A_INIT;
			seed_b = owsh_pkg::SEED_B_INIT;
			n_strings++;
		end
	endtask

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		n_bad++;
		if (n_bad <= 10)
			$display("%0t: %s: expected hash %08h, got %08h", $realtime, what, want, got);
	endfunction

	// Input side: sample acceptance, present transactions at the falling edge
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			absorb_key_byte(cur_key);
			in_taken = 1'b1;
			n_keys++;
		end
	end

	always @(negedge clk) begin
		logic nv;
		nv = in_ch.valid;
		if (in_taken) begin
			in_taken = 1'b0;
			nv = 1'b0;
		end
		if (arst_n && !nv && key_q.size() != 0) begin
			if (send_gap != 0) begin
				send_gap--;
			end else begin
				cur_key  = key_q.pop_front();
				nv       = 1'b1;
				send_gap = send_idle ? $urandom_range(0, 5) : 0;
			end
		end
		in_ch.valid <= nv;
		if (nv) begin
			in_ch.char_byte <= cur_key.ch;
			in_ch.no_char   <= cur_key.none;
			in_ch.last      <= cur_key.fin;
		end else begin
			in_ch.char_byte <= 8'($urandom);
			in_ch.no_char   <= 1'($urandom);
			in_ch.last      <= 1'($urandom);
		end
	end

	// Output side: check each hash against the oldest expectation
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			out_taken = 1'b1;
			n_hashes++;
			if (hash_q.size() == 0) begin
				note_mismatch("unexpected result", 32'd0, out_ch.hash_value);
			end else begin
				want = hash_q.pop_front();
				if (out_ch.hash_value !== want)
					note_mismatch("hash_value mismatch", want, out_ch.hash_value);
			end
		end
	end

	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 1'b0;
			recv_gap  = recv_idle ? $urandom_range(0, 5) : 0;
		end
		if (recv_gap != 0) begin
			recv_gap--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !rx_hold;
		end
	end

	// Long receiver hold-off so the pipe backs up into the input
	initial begin
		wait (hold_req);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (300) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d hashes outstanding", hash_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic push_key(input logic [7:0] ch, input logic none, input logic fin);
		key_item_t it;
		it.ch   = ch;
		it.none = none;
		it.fin  = fin;
		key_q.push_back(it);
	endtask

	// Mostly short strings, a few long ones, stray characterless transactions as noise
	task automatic queue_random_strings(input int n_items);
		int made;
		int len;
		bit closed;
		made = 0;
		while (made < n_items) begin
			case ($urandom_range(0, 9))
				0:       len = 0;
				1:       len = $urandom_range(9, 40);
				default: len = $urandom_range(1, 8);
			endcase
			closed = 1'b0;
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 11) == 0) begin
					push_key(8'($urandom), 1'b1, 1'b0);
					made++;
				end
				closed = (k == len - 1) && ($urandom_range(0, 3) != 0);
				push_key(8'($urandom), 1'b0, closed);
				made++;
			end
			if (!closed) begin
				push_key(8'($urandom), 1'b1, 1'b1);
				made++;
			end
		end
	endtask

	task automatic wait_drained();
		while (key_q.size() != 0 || in_ch.valid || hash_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_hash_type(input logic [2:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		sel_type = v;
		n_settings++;
	endtask

	initial begin
		logic [2:0] phase_types [8];
		phase_types = '{3'd4, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd0};

		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = 3'd0;
		in_ch.valid     = 1'b0;
		in_ch.char_byte = 8'd0;
		in_ch.no_char   = 1'b0;
		in_ch.last      = 1'b0;
		out_ch.ready    = 1'b0;
		build_crypt_words();
		seed_a   = owsh_pkg::SEED_A_INIT;
		seed_b   = owsh_pkg::SEED_B_INIT;
		sel_type = 3'd0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		set_hash_type(3'd0);
		send_idle = 1'b1;
		recv_idle = 1'b1;

		// Directed: empty string, byte extremes, zero byte and characterless mid-string
		push_key(8'h00, 1'b1, 1'b1);
		push_key(8'h00, 1'b0, 1'b1);
		push_key(8'hFF, 1'b0, 1'b1);
		push_key(8'h00, 1'b0, 1'b0);
		push_key(8'h3C, 1'b1, 1'b0);
		push_key(8'h80, 1'b0, 1'b0);
		push_key(8'h7F, 1'b0, 1'b0);
		push_key(8'h55, 1'b0, 1'b0);
		push_key(8'hAA, 1'b0, 1'b1);
		push_key(8'h41, 1'b0, 1'b0);
		push_key(8'h42, 1'b0, 1'b0);
		push_key(8'hC3, 1'b1, 1'b1);
		push_key(8'hFF, 1'b1, 1'b0);
		push_key(8'h01, 1'b0, 1'b1);
		push_key(8'hFF, 1'b1, 1'b1);

		foreach (phase_types[p]) begin
			wait_drained();
			set_hash_type(phase_types[p]);
			send_idle = (p % 3) != 1;
			recv_idle = (p % 4) != 2;
			if (p == 2)
				hold_req = 1'b1;
			if (p == 5) begin
				// Stop offering mid-phase until every hash is back
				queue_random_strings(40);
				wait_drained();
				queue_random_strings(40);
			end else begin
				queue_random_strings(80);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Hashed %0d key transactions forming %0d strings; %0d results compared.",
			n_keys, n_strings, n_hashes);
		$display("Ran %0d hash type settings, including all out-of-range values.", n_settings);
		if (n_bad == 0 && hash_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d hashes never arrived", n_bad, hash_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
